@@ design/lsia_pkg.sv @@
// ---------------------------------------------------------------------------
// lsia_pkg
// Shared constants, codes and control types of the lap stopwatch.
// ---------------------------------------------------------------------------
package lsia_pkg;

	localparam int COUNT_BITS  = 32;
	localparam int SPLIT_DEPTH = 4;
	localparam int ADD_W       = 25;
	localparam int CMD_W       = 3;
	localparam int LAST_W      = 29;
	localparam int IVL_W       = 10;

	localparam int DIG_W   = 4;
	localparam int MIN_W   = 6;
	localparam int HOURS_W = 23;
	localparam int DAYS_W  = 19;
	localparam int HR24_W  = 5;

	localparam int DIVISOR_W = 10;
	localparam int RADIX_B   = 2;
	localparam int DIV_STEPS = (COUNT_BITS + RADIX_B - 1) / RADIX_B;
	localparam int DIV_W     = DIV_STEPS * RADIX_B;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	localparam int SUM_W = ((COUNT_BITS > ADD_W) ? COUNT_BITS : ADD_W) + 2;

	localparam int S_TDATA_W = ((ADD_W + 7) / 8) * 8;
	localparam int OUT_BITS  = 2 * (DIG_W + MIN_W + HOURS_W + DAYS_W) + 2;
	localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam int OFS_T_DIG  = 0;
	localparam int OFS_L_DIG  = DIG_W + MIN_W + HOURS_W + DAYS_W;
	localparam int OFS_ALARM  = 2 * OFS_L_DIG;
	localparam int OFS_RUN    = OFS_ALARM + 1;

	localparam int PADDR_W = 3;

	localparam logic [DIVISOR_W-1:0] DIV_TENTHS  = DIVISOR_W'(10);
	localparam logic [DIVISOR_W-1:0] DIV_MINUTES = DIVISOR_W'(60);
	localparam logic [DIVISOR_W-1:0] DIV_HOURS   = DIVISOR_W'(24);

	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESET  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SPLIT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd5;

	localparam logic REG_INTERVAL = 1'b0;
	localparam logic REG_DAYS     = 1'b1;

	typedef enum logic [1:0] {
		PH_D10 = 2'd0,
		PH_D60 = 2'd1,
		PH_D24 = 2'd2,
		PH_INT = 2'd3
	} phase_t;

	typedef struct packed {
		logic   apply;
		logic   start;
		phase_t phase;
		logic   capture;
		logic   finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

@@ design/lsia_div.sv @@
// ---------------------------------------------------------------------------
// lsia_div
// Iterative restoring divider, two quotient bits per cycle.
// ---------------------------------------------------------------------------
module lsia_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lsia_pkg::DIV_W-1:0]        dividend,
	input  logic [lsia_pkg::DIVISOR_W-1:0]    divisor,
	output logic [lsia_pkg::DIV_W-1:0]        quotient,
	output logic [lsia_pkg::DIVISOR_W-1:0]    remainder,
	output logic                              done
);

	logic                              busy_q;
	logic                              done_q;
	logic [lsia_pkg::STEP_W-1:0]       step_q;
	logic [lsia_pkg::DIVISOR_W-1:0]    rem_q;
	logic [lsia_pkg::DIV_W-1:0]        quo_q;
	logic [lsia_pkg::DIVISOR_W-1:0]    rem_d;
	logic [lsia_pkg::DIV_W-1:0]        quo_d;
	logic [lsia_pkg::DIVISOR_W:0]      part;

	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		part  = '0;
		for (int k = 0; k < lsia_pkg::RADIX_B; k++) begin
			part  = {rem_d, quo_d[lsia_pkg::DIV_W-1]};
			quo_d = {quo_d[lsia_pkg::DIV_W-2:0], 1'b0};
			if (part >= {1'b0, divisor}) begin
				rem_d    = lsia_pkg::DIVISOR_W'(part - {1'b0, divisor});
				quo_d[0] = 1'b1;
			end else begin
				rem_d = part[lsia_pkg::DIVISOR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= lsia_pkg::STEP_W'(lsia_pkg::DIV_STEPS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == lsia_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

@@ design/lsia_ctrl.sv @@
// ---------------------------------------------------------------------------
// lsia_ctrl
// Sequencer: accept a word, run the four divide phases, load the result.
// ---------------------------------------------------------------------------
module lsia_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  lsia_pkg::ctrl_sts_t     sts,
	output lsia_pkg::ctrl_cmd_t     cmd
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_GO10  = 10'b00_0000_0010,
		ST_W10   = 10'b00_0000_0100,
		ST_GO60  = 10'b00_0000_1000,
		ST_W60   = 10'b00_0001_0000,
		ST_GO24  = 10'b00_0010_0000,
		ST_W24   = 10'b00_0100_0000,
		ST_GOINT = 10'b00_1000_0000,
		ST_WINT  = 10'b01_0000_0000,
		ST_FIN   = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.phase   = lsia_pkg::PH_D10;
		unique case (state_q)
			ST_IDLE: begin
				cmd.apply = s_tvalid;
				if (s_tvalid) state_d = ST_GO10;
			end
			ST_GO10: begin
				cmd.start = 1'b1;
				state_d   = ST_W10;
			end
			ST_W10: begin
				cmd.capture = sts.div_done;
				if (sts.div_done) state_d = ST_GO60;
			end
			ST_GO60: begin
				cmd.start = 1'b1;
				cmd.phase = lsia_pkg::PH_D60;
				state_d   = ST_W60;
			end
			ST_W60: begin
				cmd.phase   = lsia_pkg::PH_D60;
				cmd.capture = sts.div_done;
				if (sts.div_done) state_d = ST_GO24;
			end
			ST_GO24: begin
				cmd.start = 1'b1;
				cmd.phase = lsia_pkg::PH_D24;
				state_d   = ST_W24;
			end
			ST_W24: begin
				cmd.phase   = lsia_pkg::PH_D24;
				cmd.capture = sts.div_done;
				if (sts.div_done) state_d = ST_GOINT;
			end
			ST_GOINT: begin
				cmd.start = 1'b1;
				cmd.phase = lsia_pkg::PH_INT;
				state_d   = ST_WINT;
			end
			ST_WINT: begin
				cmd.phase   = lsia_pkg::PH_INT;
				cmd.capture = sts.div_done;
				if (sts.div_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = sts.out_free;
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

@@ design/lsia_dp.sv @@
// ---------------------------------------------------------------------------
// lsia_dp
// Stopwatch state, lap and field breakdown through two dividers, output word.
// ---------------------------------------------------------------------------
module lsia_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [lsia_pkg::CMD_W-1:0]        command,
	input  logic signed [lsia_pkg::ADD_W-1:0] add_tenths,
	input  logic [lsia_pkg::IVL_W-1:0]        interval_minutes,
	input  logic                              days_format,
	input  lsia_pkg::ctrl_cmd_t               cmd,
	output lsia_pkg::ctrl_sts_t               sts,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [lsia_pkg::M_TDATA_W-1:0]    m_tdata
);

	localparam logic [lsia_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [lsia_pkg::COUNT_BITS-1:0]   count_q;
	logic                              run_q;
	logic [lsia_pkg::COUNT_BITS-1:0]   split_q [lsia_pkg::SPLIT_DEPTH];
	logic [lsia_pkg::LAST_W-1:0]       last_q;

	logic signed [lsia_pkg::SUM_W-1:0] sum_s;
	logic [lsia_pkg::COUNT_BITS-1:0]   add_res;
	logic [lsia_pkg::COUNT_BITS-1:0]   lap;

	logic                              a_start;
	logic [lsia_pkg::DIV_W-1:0]        a_dvd;
	logic [lsia_pkg::DIVISOR_W-1:0]    a_dvs;
	logic [lsia_pkg::DIV_W-1:0]        a_quo;
	logic [lsia_pkg::DIVISOR_W-1:0]    a_rem;
	logic                              a_done;
	logic [lsia_pkg::DIV_W-1:0]        b_dvd;
	logic [lsia_pkg::DIVISOR_W-1:0]    b_dvs;
	logic [lsia_pkg::DIV_W-1:0]        b_quo;
	logic [lsia_pkg::DIVISOR_W-1:0]    b_rem;
	logic                              b_done;

	logic [lsia_pkg::DIG_W-1:0]        t_dig_q, l_dig_q;
	logic [lsia_pkg::DIV_W-1:0]        t_mq_q, l_mq_q;
	logic [lsia_pkg::MIN_W-1:0]        t_min_q, l_min_q;
	logic [lsia_pkg::DIV_W-1:0]        t_hr_q, l_hr_q;
	logic [lsia_pkg::HR24_W-1:0]       t_h24_q, l_h24_q;
	logic [lsia_pkg::DIV_W-1:0]        t_day_q, l_day_q;
	logic [lsia_pkg::DIVISOR_W-1:0]    ivl_rem_q;

	logic                              alarm_hit;
	logic [lsia_pkg::HOURS_W-1:0]      t_hours, l_hours;
	logic [lsia_pkg::DAYS_W-1:0]       t_days, l_days;
	logic                              out_valid_q;
	logic [lsia_pkg::M_TDATA_W-1:0]    out_data_q;

	// saturating signed add
	always_comb begin
		sum_s = $signed(lsia_pkg::SUM_W'(count_q)) + lsia_pkg::SUM_W'(add_tenths);
		if (sum_s < 0) begin
			add_res = '0;
		end else if (sum_s > $signed(lsia_pkg::SUM_W'(COUNT_MAX))) begin
			add_res = COUNT_MAX;
		end else begin
			add_res = sum_s[lsia_pkg::COUNT_BITS-1:0];
		end
	end

	assign lap = (count_q > split_q[0]) ? count_q - split_q[0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			run_q   <= 1'b0;
			last_q  <= '0;
			for (int i = 0; i < lsia_pkg::SPLIT_DEPTH; i++) split_q[i] <= '0;
		end else if (cmd.apply) begin
			unique case (command)
				lsia_pkg::CMD_TICK: begin
					if (run_q && count_q != COUNT_MAX) count_q <= count_q + 1'b1;
				end
				lsia_pkg::CMD_TOGGLE: begin
					run_q <= !run_q;
					if (!run_q) last_q <= '0;
				end
				lsia_pkg::CMD_RESET: begin
					count_q <= '0;
					run_q   <= 1'b0;
					last_q  <= '0;
					for (int i = 0; i < lsia_pkg::SPLIT_DEPTH; i++) split_q[i] <= '0;
				end
				lsia_pkg::CMD_SPLIT: begin
					if (split_q[0] != count_q) begin
						for (int i = lsia_pkg::SPLIT_DEPTH - 1; i > 0; i--) begin
							split_q[i] <= split_q[i-1];
						end
						split_q[0] <= count_q;
						last_q     <= '0;
					end
				end
				lsia_pkg::CMD_CLEAR: begin
					for (int i = 0; i < lsia_pkg::SPLIT_DEPTH; i++) split_q[i] <= '0;
				end
				lsia_pkg::CMD_ADD: begin
					count_q <= add_res;
				end
				default: begin
				end
			endcase
		end else if (cmd.finish && alarm_hit) begin
			last_q <= lsia_pkg::LAST_W'(l_mq_q);
		end
	end

	// divider operand select
	always_comb begin
		unique case (cmd.phase)
			lsia_pkg::PH_D10: begin
				a_dvd = lsia_pkg::DIV_W'(count_q);
				a_dvs = lsia_pkg::DIV_TENTHS;
				b_dvd = lsia_pkg::DIV_W'(lap);
				b_dvs = lsia_pkg::DIV_TENTHS;
			end
			lsia_pkg::PH_D60: begin
				a_dvd = t_mq_q;
				a_dvs = lsia_pkg::DIV_MINUTES;
				b_dvd = l_mq_q;
				b_dvs = lsia_pkg::DIV_MINUTES;
			end
			lsia_pkg::PH_D24: begin
				a_dvd = t_hr_q;
				a_dvs = lsia_pkg::DIV_HOURS;
				b_dvd = l_hr_q;
				b_dvs = lsia_pkg::DIV_HOURS;
			end
			lsia_pkg::PH_INT: begin
				a_dvd = t_hr_q;
				a_dvs = lsia_pkg::DIV_HOURS;
				b_dvd = l_mq_q;
				b_dvs = lsia_pkg::DIVISOR_W'(interval_minutes);
			end
			default: begin
				a_dvd = '0;
				a_dvs = lsia_pkg::DIV_TENTHS;
				b_dvd = '0;
				b_dvs = lsia_pkg::DIV_TENTHS;
			end
		endcase
	end

	assign a_start = cmd.start && (cmd.phase != lsia_pkg::PH_INT);

	lsia_div u_div_total (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (a_start),
		.dividend  (a_dvd),
		.divisor   (a_dvs),
		.quotient  (a_quo),
		.remainder (a_rem),
		.done      (a_done)
	);

	lsia_div u_div_lap (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start),
		.dividend  (b_dvd),
		.divisor   (b_dvs),
		.quotient  (b_quo),
		.remainder (b_rem),
		.done      (b_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			unique case (cmd.phase)
				lsia_pkg::PH_D10: begin
					t_dig_q <= lsia_pkg::DIG_W'(a_rem);
					t_mq_q  <= a_quo;
					l_dig_q <= lsia_pkg::DIG_W'(b_rem);
					l_mq_q  <= b_quo;
				end
				lsia_pkg::PH_D60: begin
					t_min_q <= lsia_pkg::MIN_W'(a_rem);
					t_hr_q  <= a_quo;
					l_min_q <= lsia_pkg::MIN_W'(b_rem);
					l_hr_q  <= b_quo;
				end
				lsia_pkg::PH_D24: begin
					t_h24_q <= lsia_pkg::HR24_W'(a_rem);
					t_day_q <= a_quo;
					l_h24_q <= lsia_pkg::HR24_W'(b_rem);
					l_day_q <= b_quo;
				end
				lsia_pkg::PH_INT: begin
					ivl_rem_q <= b_rem;
				end
				default: begin
				end
			endcase
		end
	end

	assign alarm_hit = (interval_minutes != '0) && (l_mq_q != '0) && (ivl_rem_q == '0)
		&& (lsia_pkg::LAST_W'(l_mq_q) != last_q) && (l_dig_q == '0);

	assign t_hours = days_format ? lsia_pkg::HOURS_W'(t_h24_q) : lsia_pkg::HOURS_W'(t_hr_q);
	assign l_hours = days_format ? lsia_pkg::HOURS_W'(l_h24_q) : lsia_pkg::HOURS_W'(l_hr_q);
	assign t_days  = days_format ? lsia_pkg::DAYS_W'(t_day_q) : '0;
	assign l_days  = days_format ? lsia_pkg::DAYS_W'(l_day_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= lsia_pkg::M_TDATA_W'({run_q, alarm_hit && run_q,
				l_days, l_hours, l_min_q, l_dig_q,
				t_days, t_hours, t_min_q, t_dig_q});
		end
	end

	assign sts.div_done = b_done;
	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;

endmodule

@@ design/lap_stopwatch_interval_alarm_top.sv @@
// ---------------------------------------------------------------------------
// lap_stopwatch_interval_alarm_top
// Stopwatch in tenths of a minute with lap splits and an interval alarm.
// ---------------------------------------------------------------------------
// Input stream: one word per command; s_tuser carries the command code,
// s_tdata the signed add offset. Every word yields one result word on the
// output stream with total and lap time broken into tenths, minutes, hours
// and days, plus the alarm pulse and the run flag.
// Timing: a word is taken in the idle state; the next word can be taken
// as soon as the result appears. The time per word is set by four divide
// phases on a pair of two-bit-per-cycle dividers (total and lap side);
// the interval phase runs the lap divider alone.
// The result sits in an output register: a stalled receiver holds it, and
// a finished word waits there while the block works on the next one; only
// a second result then waits for the register to empty.
// Reset clears the count, run flag, splits, alarm history, the two
// configuration registers and the output valid flag.
// Configuration: APB, interval_minutes at 0x0, days_format at 0x4.
// ---------------------------------------------------------------------------
module lap_stopwatch_interval_alarm_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lsia_pkg::S_TDATA_W-1:0]    s_tdata,   // add_tenths
	input  logic [lsia_pkg::CMD_W-1:0]        s_tuser,   // command
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// total_tenth_digit, total_minutes, total_hours, total_days,
	// lap_tenth_digit, lap_minutes, lap_hours, lap_days, alarm, running
	output logic [lsia_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lsia_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	logic [lsia_pkg::IVL_W-1:0]  interval_q;
	logic                        days_q;
	logic                        cfg_wr;
	lsia_pkg::ctrl_cmd_t         cmd;
	lsia_pkg::ctrl_sts_t         sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= '0;
			days_q     <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				lsia_pkg::REG_INTERVAL: interval_q <= pwdata[lsia_pkg::IVL_W-1:0];
				lsia_pkg::REG_DAYS:     days_q     <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	assign prdata = (paddr[2] == lsia_pkg::REG_DAYS) ? {31'd0, days_q}
		: 32'(interval_q);

	lsia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsia_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.command          (s_tuser),
		.add_tenths       ($signed(s_tdata[lsia_pkg::ADD_W-1:0])),
		.interval_minutes (interval_q),
		.days_format      (days_q),
		.cmd              (cmd),
		.sts              (sts),
		.m_tready         (m_tready),
		.m_tvalid         (m_tvalid),
		.m_tdata          (m_tdata)
	);

endmodule

@@ design/lsia_checker.sv @@
// ---------------------------------------------------------------------------
// lsia_checker
// Port-level checks of the stopwatch, bound to the top level.
// ---------------------------------------------------------------------------
module lsia_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [lsia_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                              pready
);

	// one word in flight: no second word straight after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("word accepted while previous word in progress");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

	a_alarm_running: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[lsia_pkg::OFS_ALARM] && !m_tdata[lsia_pkg::OFS_RUN]))
		else $error("alarm raised while stopped");

	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[lsia_pkg::OFS_T_DIG +: lsia_pkg::DIG_W] <= 4'd9)
			&& (m_tdata[lsia_pkg::OFS_L_DIG +: lsia_pkg::DIG_W] <= 4'd9))
		else $error("tenth digit out of range");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind lap_stopwatch_interval_alarm_top lsia_checker u_lsia_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
